>>> rtl/ose_pkg.sv
// Shared types and constants for the opaque span extractor.
// No dependencies; the front, queue, back and top level import it.
package ose_pkg;

    localparam int DEFAULT_MAX_WIDTH  = 2048;
    localparam int DEFAULT_MAX_HEIGHT = 2048;

    localparam logic [31:0] KEYED_PIXEL = 32'h00FF_FFFF;
    localparam logic [7:0]  ALPHA_FULL  = 8'hFF;
    localparam logic [7:0]  ALPHA_ZERO  = 8'h00;

    // configuration register indexes
    localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_COLOR_KEY    = 2'd2;
    localparam logic [1:0] CFG_KEY_ENABLE   = 2'd3;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int DIM_W       = 12;

    localparam int PIXEL_W    = 32;
    localparam int SPAN_COL_W = 11;
    localparam int SPAN_ROW_W = 11;
    localparam int SPAN_LEN_W = 12;

    // pixel, span_col, span_row, span_len, binary_alpha, padded to bytes
    localparam int M_FIELDS_W = PIXEL_W + SPAN_COL_W + SPAN_ROW_W + SPAN_LEN_W + 1;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W    = M_TDATA_W - M_FIELDS_W;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);

    // one classified pixel between front and back
    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               alpha_zero;
        logic               alpha_nonbin;
    } entry_t;

endpackage

>>> rtl/ose_front.sv
// Front stage: color-key replacement and alpha classification of each pixel.
// Depends on ose_pkg; feeds ose_queue.
module ose_front (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [31:0]            s_pixel,
    input  logic                   key_enable,
    input  logic [31:0]            color_key,
    output logic                   q_push,
    output ose_pkg::entry_t        q_entry,
    input  logic                   q_full
);
    import ose_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    entry_t entry_reg;
    entry_t entry_next;
    logic [PIXEL_W-1:0] keyed;
    logic [7:0]         alpha;
    logic               advance;

    always_comb begin
        keyed = (key_enable && (s_pixel == color_key)) ? KEYED_PIXEL : s_pixel;
        alpha = keyed[31:24];
        entry_next.pixel        = keyed;
        entry_next.alpha_zero   = (alpha == ALPHA_ZERO);
        entry_next.alpha_nonbin = (alpha != ALPHA_ZERO) && (alpha != ALPHA_FULL);
    end

    assign q_push  = valid_reg && !q_full;
    assign advance = !valid_reg || !q_full;
    assign s_ready = advance;
    assign q_entry = entry_reg;

    always_comb begin
        valid_next = valid_reg;
        if (advance) begin
            valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && s_valid) begin
            entry_reg <= entry_next;
        end
    end

endmodule

>>> rtl/ose_queue.sv
// Short queue of classified pixels between front and back.
// Depends on ose_pkg.
module ose_queue (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        push,
    input  ose_pkg::entry_t             push_entry,
    output logic                        full,
    input  logic                        pop,
    output ose_pkg::entry_t             pop_entry,
    output logic                        not_empty,
    output logic [ose_pkg::QLVL_W-1:0]  level
);
    import ose_pkg::*;

    entry_t             mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QLVL_W-1:0]  level_reg;
    logic [QLVL_W-1:0]  level_next;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        logic [QPTR_W-1:0] r;
        if (QLVL_W'(p) == QLVL_W'(QUEUE_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    assign full      = (level_reg == QLVL_W'(QUEUE_DEPTH));
    assign not_empty = (level_reg != '0);
    assign level     = level_reg;
    assign pop_entry = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        level_next  = level_reg;
        if (push && !pop) begin
            level_next = level_reg + 1'b1;
        end else if (pop && !push) begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

>>> rtl/ose_back.sv
// Back stage: row/column tracking, opaque run detection and span reporting,
// with the output register. Depends on ose_pkg; pulls from ose_queue.
module ose_back #(
    parameter  int MAX_WIDTH  = ose_pkg::DEFAULT_MAX_WIDTH,
    parameter  int MAX_HEIGHT = ose_pkg::DEFAULT_MAX_HEIGHT,
    localparam int CW         = $clog2(MAX_WIDTH),
    localparam int RW         = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            q_valid,
    input  ose_pkg::entry_t                 q_entry,
    output logic                            q_pop,
    input  logic [CW-1:0]                   last_col,
    input  logic [RW-1:0]                   last_row,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ose_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                            m_tlast,
    output logic                            m_tuser
);
    import ose_pkg::*;

    logic [CW-1:0] col_reg;
    logic [CW-1:0] col_next;
    logic [RW-1:0] row_reg;
    logic [RW-1:0] row_next;
    logic          run_open_reg;
    logic          run_open_next;
    logic [CW-1:0] run_start_reg;
    logic [CW-1:0] run_start_next;
    logic          all_bin_reg;
    logic          all_bin_next;
    logic          m_valid_reg;
    logic          m_valid_next;

    logic [M_TDATA_W-1:0] tdata_reg;
    logic [M_TDATA_W-1:0] tdata_next;
    logic                 tlast_reg;
    logic                 tlast_next;
    logic                 tuser_reg;
    logic                 tuser_next;

    logic          close_zero;
    logic          open_now;
    logic          run_open_mid;
    logic [CW-1:0] start_mid;
    logic          row_end;
    logic          is_last_row;
    logic          close_end;
    logic          span;
    logic          done;
    logic [CW:0]   len_w;
    logic [SPAN_COL_W-1:0] span_col;
    logic [SPAN_ROW_W-1:0] span_row;
    logic [SPAN_LEN_W-1:0] span_len;

    assign q_pop = q_valid && (!m_valid_reg || m_tready);

    always_comb begin
        all_bin_next = all_bin_reg && !q_entry.alpha_nonbin;
        close_zero   = q_entry.alpha_zero && run_open_reg;
        open_now     = !q_entry.alpha_zero && !run_open_reg;
        run_open_mid = close_zero ? 1'b0 : (open_now ? 1'b1 : run_open_reg);
        start_mid    = open_now ? col_reg : run_start_reg;
        row_end      = (col_reg >= last_col);
        is_last_row  = (row_reg >= last_row);
        close_end    = row_end && run_open_mid;
        span         = close_zero || close_end;
        done         = row_end && is_last_row;
        // a run closed at the row end includes the current pixel
        len_w        = {1'b0, col_reg} - {1'b0, start_mid} + (CW + 1)'(close_end);
        span_col     = span ? SPAN_COL_W'(start_mid) : '0;
        span_row     = span ? SPAN_ROW_W'(row_reg) : '0;
        span_len     = span ? SPAN_LEN_W'(len_w) : '0;

        tdata_next = {{M_PAD_W{1'b0}}, all_bin_next, span_len, span_row, span_col,
                      q_entry.pixel};
        tlast_next = done;
        tuser_next = span;

        col_next       = col_reg;
        row_next       = row_reg;
        run_open_next  = run_open_reg;
        run_start_next = run_start_reg;
        if (q_pop) begin
            run_open_next  = run_open_mid && !close_end;
            run_start_next = start_mid;
            if (done) begin
                col_next       = '0;
                row_next       = '0;
                run_open_next  = 1'b0;
                run_start_next = '0;
            end else if (row_end) begin
                col_next = '0;
                row_next = row_reg + 1'b1;
            end else begin
                col_next = col_reg + 1'b1;
            end
        end

        m_valid_next = m_valid_reg;
        if (q_pop) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg       <= '0;
            row_reg       <= '0;
            run_open_reg  <= 1'b0;
            run_start_reg <= '0;
            all_bin_reg   <= 1'b1;
            m_valid_reg   <= 1'b0;
        end else begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            run_open_reg  <= run_open_next;
            run_start_reg <= run_start_next;
            if (q_pop) begin
                all_bin_reg <= done ? 1'b1 : all_bin_next;
            end
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            tdata_reg <= tdata_next;
            tlast_reg <= tlast_next;
            tuser_reg <= tuser_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tlast  = tlast_reg;
    assign m_tuser  = tuser_reg;

endmodule

>>> rtl/opaque_span_extractor.sv
// Opaque span extractor: color keying, opaque run detection, span reporting.
// Each input beat passes the front register, the queue and the back output register;
// sustains one pixel per cycle while m_tready is high.
// While a result waits at the output, the queue and front register take up to
// three more beats, then s_tready drops.
// aresetn is synchronous; reset loads width 1, height 1, key 0, keying off.
// Depends on ose_pkg, ose_front, ose_queue, ose_back.
module opaque_span_extractor #(
    parameter int MAX_WIDTH  = ose_pkg::DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = ose_pkg::DEFAULT_MAX_HEIGHT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [31:0]                       s_tdata,   // [31:0] pixel_in
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [31:0] pixel_out, [42:32] span_col, [53:43] span_row, [65:54] span_len,
    // [66] binary_alpha, rest zero
    output logic [ose_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                              m_tlast,   // image_done
    output logic                              m_tuser,   // [0] span_valid
    input  logic                              cfg_we,
    input  logic [ose_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ose_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import ose_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [31:0]      color_key_reg;
    logic             key_enable_reg;
    logic [CW-1:0]    last_col_reg;
    logic [CW-1:0]    last_col_next;
    logic [RW-1:0]    last_row_reg;
    logic [RW-1:0]    last_row_next;

    logic              q_push;
    logic              q_full;
    logic              q_pop;
    logic              q_not_empty;
    logic [QLVL_W-1:0] q_level;
    entry_t            front_entry;
    entry_t            back_entry;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg      <= DIM_W'(1);
            height_reg     <= DIM_W'(1);
            color_key_reg  <= '0;
            key_enable_reg <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:  width_reg      <= cfg_wdata[DIM_W-1:0];
                CFG_IMAGE_HEIGHT: height_reg     <= cfg_wdata[DIM_W-1:0];
                CFG_COLOR_KEY:    color_key_reg  <= cfg_wdata[31:0];
                CFG_KEY_ENABLE:   key_enable_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // clamped dimensions minus one, registered from the configuration registers
    always_comb begin
        if (width_reg == '0) begin
            last_col_next = '0;
        end else if (32'(width_reg) > 32'(MAX_WIDTH)) begin
            last_col_next = CW'(MAX_WIDTH - 1);
        end else begin
            last_col_next = CW'(width_reg - 1'b1);
        end
        if (height_reg == '0) begin
            last_row_next = '0;
        end else if (32'(height_reg) > 32'(MAX_HEIGHT)) begin
            last_row_next = RW'(MAX_HEIGHT - 1);
        end else begin
            last_row_next = RW'(height_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_col_reg <= '0;
            last_row_reg <= '0;
        end else begin
            last_col_reg <= last_col_next;
            last_row_reg <= last_row_next;
        end
    end

    ose_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_pixel    (s_tdata),
        .key_enable (key_enable_reg),
        .color_key  (color_key_reg),
        .q_push     (q_push),
        .q_entry    (front_entry),
        .q_full     (q_full)
    );

    ose_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (front_entry),
        .full       (q_full),
        .pop        (q_pop),
        .pop_entry  (back_entry),
        .not_empty  (q_not_empty),
        .level      (q_level)
    );

    ose_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_not_empty),
        .q_entry  (back_entry),
        .q_pop    (q_pop),
        .last_col (last_col_reg),
        .last_row (last_row_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // queue never overfills
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_level <= QLVL_W'(QUEUE_DEPTH))
        else $error("queue level above depth");

    // beats without span_valid leave the span fields clear
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata[65:32] == '0))
        else $error("span fields set without span");

    // a reported span always covers at least one pixel
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[65:54] != '0))
        else $error("empty span reported");

    // a pop only happens when the queue holds an entry
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> (q_level != '0))
        else $error("pop from empty queue");

endmodule
